// ===== rtl/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler to quaternion package
// Shared constants, the arctangent table and the trig types.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int XY_BITS      = 44;   // 40 fraction bits plus sign and headroom
    localparam int ANG_BITS     = 34;
    localparam int TRIG_BITS    = 32;   // 30 fraction bits, signed

    localparam logic signed [XY_BITS-1:0] GAIN_INV = 44'sd667681663044;

    typedef logic signed [TRIG_BITS-1:0] trig_t;

    typedef struct packed {
        trig_t c;
        trig_t s;
    } cs_t;

    function automatic logic signed [ANG_BITS-1:0] atan_turn(input logic [4:0] i);
        logic signed [ANG_BITS-1:0] r;
        begin
            r = '0;
            unique case (i)
                5'd0:  r = 34'sd536870912;
                5'd1:  r = 34'sd316933406;
                5'd2:  r = 34'sd167458907;
                5'd3:  r = 34'sd85004756;
                5'd4:  r = 34'sd42667331;
                5'd5:  r = 34'sd21354465;
                5'd6:  r = 34'sd10680862;
                5'd7:  r = 34'sd5340245;
                5'd8:  r = 34'sd2670675;
                5'd9:  r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                5'd24: r = 34'sd41;
                5'd25: r = 34'sd20;
                5'd26: r = 34'sd10;
                5'd27: r = 34'sd5;
                5'd28: r = 34'sd3;
                5'd29: r = 34'sd1;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/e2q_cordic.sv =====
// ----------------------------------------------------------------------------
// Euler to quaternion CORDIC
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, giving the
// cosine and sine of a half angle at 30 fraction bits.
// ----------------------------------------------------------------------------
module e2q_cordic #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output e2q_pkg::cs_t          cs
);
    import e2q_pkg::*;

    localparam int N = CORDIC_STEPS;

    logic signed [XY_BITS-1:0]  x_reg [0:N];
    logic signed [XY_BITS-1:0]  y_reg [0:N];
    logic signed [ANG_BITS-1:0] z_reg [0:N];
    logic signed [31:0]         a32;
    logic signed [XY_BITS-1:0]  c_round;
    logic signed [XY_BITS-1:0]  s_round;

    // Scale to a 32-bit binary angle; the half angle is an arithmetic shift.
    generate
        if (ANGLE_BITS >= 32) begin : g_wide
            assign a32 = angle[31:0];
        end else begin : g_narrow
            assign a32 = {angle, {(32-ANGLE_BITS){1'b0}}};
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= GAIN_INV;
            y_reg[0] <= '0;
            z_reg[0] <= ANG_BITS'(a32 >>> 1);
            for (int k = 0; k < N; k++)
            begin
                if (!z_reg[k][ANG_BITS-1])
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - atan_turn(5'(k));
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + atan_turn(5'(k));
                end
            end
        end
    end

    assign c_round = (x_reg[N] + XY_BITS'(512)) >>> 10;
    assign s_round = (y_reg[N] + XY_BITS'(512)) >>> 10;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs.c <= c_round[TRIG_BITS-1:0];
            cs.s <= s_round[TRIG_BITS-1:0];
        end
    end

    // Reset is unused: the stages are payload only.
    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

// ===== rtl/e2q_combine.sv =====
// ----------------------------------------------------------------------------
// Euler to quaternion combiner
// Forms the four quaternion components from the six cosines and sines
// over a pair-product stage, a rounding stage, a term-product stage and a rounding and clamping stage.
// ----------------------------------------------------------------------------
module e2q_combine #(
    parameter int FRAC_BITS = 14
) (
    input  logic                     clk,
    input  logic                     en,
    input  e2q_pkg::cs_t             r,
    input  e2q_pkg::cs_t             p,
    input  e2q_pkg::cs_t             y,
    output logic [4*(FRAC_BITS+2)-1:0] quat
);
    import e2q_pkg::*;

    localparam int OB = FRAC_BITS + 2;
    localparam int SH = 60 - FRAC_BITS;

    // Pair products of roll and pitch: cc, sc, cs, ss.
    logic signed [63:0] pp_reg [0:3];
    trig_t cy_reg, sy_reg, cy2_reg, sy2_reg;
    // A rounded pair product stays within one, so it fits the trig width.
    trig_t              rp_reg [0:3];
    logic signed [63:0] t_reg  [0:7];
    logic signed [63:0] sum    [0:3];
    logic signed [63:0] rnd    [0:3];
    logic signed [63:0] one;

    assign one = 64'sd1 <<< FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg[0] <= 64'(r.c) * 64'(p.c);
            pp_reg[1] <= 64'(r.s) * 64'(p.c);
            pp_reg[2] <= 64'(r.c) * 64'(p.s);
            pp_reg[3] <= 64'(r.s) * 64'(p.s);
            cy_reg <= y.c;
            sy_reg <= y.s;
            for (int k = 0; k < 4; k++)
                rp_reg[k] <= TRIG_BITS'((pp_reg[k] + 64'sd536870912) >>> 30);
            cy2_reg <= cy_reg;
            sy2_reg <= sy_reg;
            // Terms: w: cc*cy, ss*sy; x: sc*cy, cs*sy; y: cs*cy, sc*sy;
            // z: cc*sy, ss*cy.
            t_reg[0] <= 64'(rp_reg[0]) * 64'(cy2_reg);
            t_reg[1] <= 64'(rp_reg[3]) * 64'(sy2_reg);
            t_reg[2] <= 64'(rp_reg[1]) * 64'(cy2_reg);
            t_reg[3] <= 64'(rp_reg[2]) * 64'(sy2_reg);
            t_reg[4] <= 64'(rp_reg[2]) * 64'(cy2_reg);
            t_reg[5] <= 64'(rp_reg[1]) * 64'(sy2_reg);
            t_reg[6] <= 64'(rp_reg[0]) * 64'(sy2_reg);
            t_reg[7] <= 64'(rp_reg[3]) * 64'(cy2_reg);
            for (int k = 0; k < 4; k++)
            begin
                if (rnd[k] > one)
                    quat[k*OB +: OB] <= OB'(one);
                else if (rnd[k] < -one)
                    quat[k*OB +: OB] <= OB'(-one);
                else
                    quat[k*OB +: OB] <= OB'(rnd[k]);
            end
        end
    end

    always_comb
    begin
        sum[0] = t_reg[0] + t_reg[1];
        sum[1] = t_reg[2] - t_reg[3];
        sum[2] = t_reg[4] + t_reg[5];
        sum[3] = t_reg[6] - t_reg[7];
        for (int k = 0; k < 4; k++)
            rnd[k] = (sum[k] + (64'sd1 <<< (SH - 1))) >>> SH;
    end

endmodule

// ===== rtl/euler_to_quaternion_top.sv =====
// ----------------------------------------------------------------------------
// Euler to quaternion top
// Channel  Dir  Fields (low bit first)
// s_axis   in   roll_angle, pitch_angle, yaw_angle
// m_axis   out  quat_w, quat_x, quat_y, quat_z
// One request per cycle unless the output stalls; the path is 30 CORDIC
// stages plus input, rounding, pair-product, rounding, term-product and clamp registers.
// The whole pipeline advances together and halts when the output holds
// a result that is not taken, so a stall loses and repeats nothing.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module euler_to_quaternion_top #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // roll_angle, pitch_angle, yaw_angle
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // quat_w, quat_x, quat_y, quat_z
    output logic [((4*(FRAC_BITS+2)+7)/8)*8-1:0]  m_axis_tdata
);
    import e2q_pkg::*;

    localparam int LAT = CORDIC_STEPS + 6;
    localparam int QW  = 4*(FRAC_BITS+2);
    localparam int OW  = ((QW+7)/8)*8;

    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic           en;
    cs_t            cs_r, cs_p, cs_y;
    logic [QW-1:0]  quat;

    assign en            = !vld_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];
    assign vld_next      = {vld_reg[LAT-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_roll (
        .clk(clk), .rst_n(rst_n), .en(en),
        .angle(s_axis_tdata[ANGLE_BITS-1:0]), .cs(cs_r));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_pitch (
        .clk(clk), .rst_n(rst_n), .en(en),
        .angle(s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]), .cs(cs_p));
    e2q_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_yaw (
        .clk(clk), .rst_n(rst_n), .en(en),
        .angle(s_axis_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]), .cs(cs_y));

    e2q_combine #(.FRAC_BITS(FRAC_BITS)) u_comb (
        .clk(clk), .en(en), .r(cs_r), .p(cs_p), .y(cs_y), .quat(quat));

    assign m_axis_tdata = OW'(quat);

`ifndef SYNTH
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> vld_reg[0])
        else $error("accepted request not tracked");
`endif

endmodule
